FILE: design/slsh_pkg.sv
// Package for the simplex SVM error unit with Huber hinge.
// Holds default sizes, function and register codes, shared types and helpers.
// No dependencies.
package slsh_pkg;

	localparam int MAX_FEATURES_D = 256;
	localparam int MAX_CLASSES_D  = 16;
	localparam int FRAC_BITS_D    = 24;

	// Item function codes.
	localparam logic [1:0] FUNC_WR_WEIGHT  = 2'd0;
	localparam logic [1:0] FUNC_WR_SIMPLEX = 2'd1;
	localparam logic [1:0] FUNC_FEATURE    = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KAPPA       = 4'd1;

	// Divider widths: 64-bit dividend, divisor 2*(kappa+1).
	localparam int NUM_W = 64;
	localparam int DEN_W = 34;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Clamp a 64-bit signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic hi_ok;
		begin
			hi_ok = (x[63:31] == {33{1'b0}}) || (x[63:31] == {33{1'b1}});
			if (hi_ok)
				sat32 = x[31:0];
			else if (x[63])
				sat32 = 32'sh8000_0000;
			else
				sat32 = 32'sh7FFF_FFFF;
		end
	endfunction

	// 64-bit add with saturation.
	function automatic logic signed [63:0] satadd64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63])
				satadd64 = s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
			else
				satadd64 = s[63:0];
		end
	endfunction

endpackage

FILE: design/slsh_if.sv
// Handshake channels of the simplex SVM error unit: items, results, config.
// Depends on slsh_pkg for the configuration index width.
interface slsh_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [7:0]         row;
	logic [3:0]         col;
	logic signed [31:0] value;
	logic [4:0]         label;
	logic               last;
	modport source (output valid, func, row, col, value, label, last, input ready);
	modport sink (input valid, func, row, col, value, label, last, output ready);
endinterface

interface slsh_result_if;
	logic               valid;
	logic               ready;
	logic [3:0]         class_index;
	logic signed [31:0] scalar_error;
	logic [30:0]        huber_error;
	logic               last_class;
	modport source (output valid, class_index, scalar_error, huber_error, last_class,
		input ready);
	modport sink (input valid, class_index, scalar_error, huber_error, last_class,
		output ready);
endinterface

interface slsh_cfg_if
	import slsh_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/slsh_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on nothing; the sequencer in the top level drives its operands.
module slsh_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_s1
);

	// Product is registered and available in the cycle after the operands.
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

FILE: design/slsh_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on slsh_pkg for widths and the status struct.
module slsh_div
	import slsh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// Shift in the next dividend bit and try the subtraction.
	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo   <= {quo[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: design/simplex_svm_error_huber.sv
// Simplex SVM error unit with Huber hinge; top level and sequencer.
// A table write is taken only while idle; a feature item steps read, multiply, accumulate per
// column on the shared multiplier. The last feature adds a class pass: per class a dot product,
// the hinge (through the divider when it applies) and one output transaction.
// Reset clears the accumulators, feature counter and registers (K=2, kappa=0); tables stay as
// they are.
module simplex_svm_error_huber
	import slsh_pkg::*;
#(
	parameter int MAX_FEATURES = MAX_FEATURES_D,
	parameter int MAX_CLASSES  = MAX_CLASSES_D,
	parameter int FRAC_BITS    = FRAC_BITS_D
) (
	input  logic clk,
	input  logic arst_n,
	slsh_item_if.sink     items,
	slsh_result_if.source results,
	slsh_cfg_if.sink      cfg
);

	localparam int NCOL   = MAX_CLASSES - 1;
	localparam int KMAX   = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;
	localparam int ACC_N  = KMAX - 1;
	localparam int AIW    = (ACC_N > 1) ? $clog2(ACC_N) : 1;
	localparam int WDEPTH = MAX_FEATURES * NCOL;
	localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int SDEPTH = MAX_CLASSES * NCOL;
	localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int FCW    = $clog2(MAX_FEATURES + 1);
	localparam logic signed [35:0] ONE36 = 36'sd1 <<< FRAC_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FRD  = 4'd1;
	localparam logic [3:0] S_FMUL = 4'd2;
	localparam logic [3:0] S_FACC = 4'd3;
	localparam logic [3:0] S_CA   = 4'd4;
	localparam logic [3:0] S_CB   = 4'd5;
	localparam logic [3:0] S_CD   = 4'd6;
	localparam logic [3:0] S_CM   = 4'd7;
	localparam logic [3:0] S_CS   = 4'd8;
	localparam logic [3:0] S_HB   = 4'd9;
	localparam logic [3:0] S_HC   = 4'd10;
	localparam logic [3:0] S_SQ   = 4'd11;
	localparam logic [3:0] S_DST  = 4'd12;
	localparam logic [3:0] S_DIV  = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	logic [3:0]          state_q;
	logic [4:0]          nc_q;
	logic signed [31:0]  kappa_q;
	logic [FCW-1:0]      fc_q;
	logic [WA_W-1:0]     wbase_q;
	logic [3:0]          j_q;
	logic [4:0]          k_q;
	logic [3:0]          y_q;
	logic                last_q;
	logic signed [31:0]  val_q;
	logic signed [63:0]  acc_q [ACC_N];
	logic signed [31:0]  uy_q;
	logic signed [32:0]  diff_q;
	logic signed [31:0]  zv_q;
	logic signed [63:0]  qacc_q;
	logic signed [31:0]  q_q;
	logic signed [32:0]  d_q;
	logic [30:0]         h_q;

	logic [31:0]         wmem [WDEPTH];
	logic [31:0]         smem [SDEPTH];
	logic signed [31:0]  wrd_q;
	logic signed [31:0]  srd_q;

	logic [4:0]          kuse;
	logic [4:0]          ylab;
	logic                in_acc;
	logic                w_we;
	logic                s_we;
	logic [WA_W-1:0]     w_wa;
	logic [SA_W-1:0]     s_wa;
	logic [WA_W-1:0]     w_ra;
	logic [SA_W-1:0]     s_ra;
	logic signed [32:0]  mul_a;
	logic signed [32:0]  mul_b;
	logic signed [65:0]  prod_s1;
	logic signed [63:0]  prod_sh;
	logic                j_more;
	logic                k_last;
	logic signed [32:0]  kap_e;
	logic signed [35:0]  kp1;
	logic signed [35:0]  q36;
	logic signed [35:0]  hlin;
	logic [DEN_W-1:0]    den;
	logic                div_start;
	div_stat_t           div_st;
	logic [NUM_W-1:0]    div_quo;

	// Classes in use and the zero-based label row.
	always_comb begin
		kuse = nc_q;
		if (kuse < 5'd2)
			kuse = 5'd2;
		if (kuse > 5'(KMAX))
			kuse = 5'(KMAX);
		ylab = (items.label == 5'd0) ? 5'd1 : items.label;
		if (ylab > kuse)
			ylab = kuse;
		ylab = ylab - 5'd1;
	end

	assign in_acc      = items.valid && items.ready;
	assign items.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q    <= 5'd2;
			kappa_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_NUM_CLASSES: nc_q    <= cfg.data[4:0];
				CFG_KAPPA:       kappa_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Table write decode and read addresses.
	assign w_we = in_acc && (items.func == FUNC_WR_WEIGHT)
		&& (32'(items.row) < 32'(MAX_FEATURES)) && (32'(items.col) < 32'(NCOL));
	assign s_we = in_acc && (items.func == FUNC_WR_SIMPLEX)
		&& (32'(items.row) < 32'(MAX_CLASSES)) && (32'(items.col) < 32'(NCOL));
	assign w_wa = WA_W'(items.row) * WA_W'(NCOL) + WA_W'(items.col);
	assign s_wa = SA_W'(items.row) * SA_W'(NCOL) + SA_W'(items.col);
	assign w_ra = wbase_q + WA_W'(j_q);
	assign s_ra = (state_q == S_CA) ? (SA_W'(y_q) * SA_W'(NCOL) + SA_W'(j_q))
		: (SA_W'(k_q) * SA_W'(NCOL) + SA_W'(j_q));

	// Weight store.
	always_ff @(posedge clk) begin
		if (w_we)
			wmem[w_wa] <= items.value;
		wrd_q <= wmem[w_ra];
	end

	// Simplex table.
	always_ff @(posedge clk) begin
		if (s_we)
			smem[s_wa] <= items.value;
		srd_q <= smem[s_ra];
	end

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_FMUL: begin
				mul_a = 33'(val_q);
				mul_b = 33'(wrd_q);
			end
			S_CM: begin
				mul_a = 33'(zv_q);
				mul_b = diff_q;
			end
			S_SQ: begin
				mul_a = d_q;
				mul_b = d_q;
			end
			default: ;
		endcase
	end

	slsh_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_s1(prod_s1)
	);

	assign prod_sh = 64'(prod_s1 >>> FRAC_BITS);
	assign j_more  = (5'(j_q) + 5'd2) < kuse;
	assign k_last  = (k_q + 5'd1) == kuse;

	// Hinge operands: kappa held above minus one.
	always_comb begin
		kap_e = 33'(kappa_q);
		if (36'(kap_e) <= -ONE36)
			kap_e = 33'(-ONE36 + 36'sd1);
		kp1  = 36'(kap_e) + ONE36;
		q36  = 36'(q_q);
		hlin = ONE36 - q36 - (kp1 >>> 1);
		den  = DEN_W'(kp1 <<< 1);
	end

	assign div_start = (state_q == S_DST);

	slsh_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_s1[NUM_W-1:0]),
		.den   (den),
		.stat  (div_st),
		.quo   (div_quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fc_q    <= '0;
			wbase_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
			y_q     <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < ACC_N; i++)
				acc_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (items.func == FUNC_FEATURE)) begin
						last_q <= items.last;
						y_q    <= ylab[3:0];
						j_q    <= '0;
						k_q    <= '0;
						if (fc_q < FCW'(MAX_FEATURES))
							state_q <= S_FRD;
						else if (items.last)
							state_q <= S_CA;
					end
				end
				S_FRD:  state_q <= S_FMUL;
				S_FMUL: state_q <= S_FACC;
				S_FACC: begin
					acc_q[j_q[AIW-1:0]] <= satadd64(acc_q[j_q[AIW-1:0]], prod_sh);
					if (j_more) begin
						j_q     <= j_q + 4'd1;
						state_q <= S_FRD;
					end else begin
						j_q     <= '0;
						fc_q    <= fc_q + 1'b1;
						wbase_q <= wbase_q + WA_W'(NCOL);
						state_q <= last_q ? S_CA : S_IDLE;
					end
				end
				S_CA: state_q <= S_CB;
				S_CB: state_q <= S_CD;
				S_CD: state_q <= S_CM;
				S_CM: state_q <= S_CS;
				S_CS: begin
					if (j_more) begin
						j_q     <= j_q + 4'd1;
						state_q <= S_CA;
					end else begin
						state_q <= S_HB;
					end
				end
				S_HB: state_q <= S_HC;
				S_HC: begin
					if (q36 <= -36'(kap_e))
						state_q <= S_OUT;
					else if (q36 <= ONE36)
						state_q <= S_SQ;
					else
						state_q <= S_OUT;
				end
				S_SQ:  state_q <= S_DST;
				S_DST: state_q <= S_DIV;
				S_DIV: begin
					if (div_st.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (results.ready) begin
						j_q <= '0;
						if (k_last) begin
							fc_q    <= '0;
							wbase_q <= '0;
							for (int i = 0; i < ACC_N; i++)
								acc_q[i] <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 5'd1;
							state_q <= S_CA;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item value capture and class pass datapath.
	always_ff @(posedge clk) begin
		if (in_acc)
			val_q <= items.value;
		if ((state_q == S_IDLE) || (state_q == S_OUT))
			qacc_q <= '0;
		if (state_q == S_CB)
			uy_q <= srd_q;
		if (state_q == S_CD) begin
			diff_q <= 33'(uy_q) - 33'(srd_q);
			zv_q   <= sat32(acc_q[j_q[AIW-1:0]]);
		end
		if (state_q == S_CS)
			qacc_q <= qacc_q + prod_sh;
		if (state_q == S_HB)
			q_q <= sat32(qacc_q);
		if (state_q == S_HC) begin
			d_q <= 33'(ONE36 - q36);
			if (q36 <= -36'(kap_e)) begin
				if (hlin < 36'sd0)
					h_q <= '0;
				else if (hlin > 36'sh0_7FFF_FFFF)
					h_q <= '1;
				else
					h_q <= hlin[30:0];
			end else begin
				h_q <= '0;
			end
		end
		if ((state_q == S_DIV) && div_st.done)
			h_q <= (|div_quo[NUM_W-1:31]) ? '1 : div_quo[30:0];
	end

	// Result channel.
	assign results.valid        = (state_q == S_OUT);
	assign results.class_index  = k_q[3:0];
	assign results.scalar_error = q_q;
	assign results.huber_error  = h_q;
	assign results.last_class   = k_last;

`ifndef SYNTHESIS
	a_no_accept_during_result: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !items.ready)
		else $error("item accepted while a result is pending");
	a_zero_above_one: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (36'(results.scalar_error) > ONE36)) |-> (results.huber_error == '0))
		else $error("hinge nonzero for error above one");
	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FCW'(MAX_FEATURES))
		else $error("feature counter past limit");
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == S_DIV))
		else $error("divider busy outside divide state");
`endif

endmodule
